// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/swg_pkg.sv =====
`default_nettype none
package swg_pkg;

    // fraction bits of the sine before amplitude scaling
    localparam int SIN_FRAC = 16;
    localparam int SIN_W    = SIN_FRAC + 2;
    localparam int PROD_W   = SIN_W + 32;
    localparam int V_W      = 34;
    localparam int PR_W     = V_W + 25;
    localparam int N_W      = 43;

    // divider cell chain geometry
    localparam int DIV_BITS  = 4;
    localparam int DIV_CELLS = 15;
    localparam int NUM_W     = DIV_BITS * DIV_CELLS;
    localparam int DEN_W     = 24;
    localparam int AUX_W     = 16;

    // phase: frac of f * ms / 1000 in Q0.32 is (f * ms << 13) / 125
    localparam int PHASE_SHIFT = 13;
    localparam int PHASE_DEN   = 125;

    // exact division by 125: subtract the remainder, multiply by the
    // inverse of 125 modulo 2^32; the remainder comes from 7-bit chunks
    localparam int          PH_CHUNKS = 6;
    localparam logic [31:0] PHASE_INV = 32'd652835029;

    localparam int HORNER_CELLS = 6;
    localparam int LAT = DIV_CELLS + HORNER_CELLS + 12;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_FREQ     = 3'd0,
        REG_PHASE    = 3'd1,
        REG_AMP      = 3'd2,
        REG_OFFSET   = 3'd3,
        REG_DECIMALS = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [31:0] time_seconds;
        logic [9:0]  time_millis;
    } time_t;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               saturated;
    } sample_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [AUX_W-1:0] aux;
    } div_cell_t;

    typedef struct packed {
        logic signed [31:0] acc;
        logic [30:0]        u;
        logic [30:0]        u2;
        logic [1:0]         quad;
    } horner_t;

    // taylor coefficients of sin(pi/2 * u), Q30
    function automatic logic signed [31:0] sin_coef(input logic [2:0] idx);
        logic signed [31:0] c;
        case (idx)
            3'd0:    c = 32'sd1686629713;
            3'd1:    c = -32'sd693598668;
            3'd2:    c = 32'sd85569306;
            3'd3:    c = -32'sd5026995;
            3'd4:    c = 32'sd172272;
            3'd5:    c = -32'sd3864;
            3'd6:    c = 32'sd61;
            default: c = 32'sd0;
        endcase
        return c;
    endfunction

    // 2^(7 * idx + 13) modulo 125, weight of one 7-bit chunk of f * ms
    function automatic logic [6:0] phase_weight(input logic [2:0] idx);
        logic [6:0] w;
        case (idx)
            3'd0:    w = 7'd67;
            3'd1:    w = 7'd76;
            3'd2:    w = 7'd103;
            3'd3:    w = 7'd59;
            3'd4:    w = 7'd52;
            3'd5:    w = 7'd31;
            default: w = 7'd0;
        endcase
        return w;
    endfunction

    function automatic logic [DEN_W-1:0] pow10(input logic [2:0] idx);
        logic [DEN_W-1:0] p;
        case (idx)
            3'd0:    p = DEN_W'(1);
            3'd1:    p = DEN_W'(10);
            3'd2:    p = DEN_W'(100);
            3'd3:    p = DEN_W'(1000);
            3'd4:    p = DEN_W'(10000);
            3'd5:    p = DEN_W'(100000);
            3'd6:    p = DEN_W'(1000000);
            default: p = DEN_W'(10000000);
        endcase
        return p;
    endfunction

    // (a * b) >> 30 truncated toward zero, b non-negative
    function automatic logic signed [33:0] mul_q30(input logic signed [31:0] a,
                                                   input logic [30:0] b);
        logic [31:0] a_mag;
        logic [62:0] p;
        logic [32:0] t;
        a_mag = a[31] ? 32'(-a) : 32'(a);
        p     = 63'(a_mag) * 63'(b);
        t     = p[62:30];
        return a[31] ? -$signed({1'b0, t}) : $signed({1'b0, t});
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/swg_div_cell.sv =====
`default_nettype none
module swg_div_cell import swg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      en,
    input  wire div_cell_t din,
    output div_cell_t      dout
);

    div_cell_t          cell_next;
    div_cell_t          cell_reg;
    logic [DEN_W:0]     trial;

    // DIV_BITS restoring division steps, one quotient bit each
    always_comb
    begin
        cell_next = din;
        trial     = '0;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            trial         = {cell_next.rem, cell_next.num[NUM_W-1]};
            cell_next.num = cell_next.num << 1;
            cell_next.quo = cell_next.quo << 1;
            if (trial >= {1'b0, cell_next.den})
            begin
                cell_next.rem    = DEN_W'(trial - {1'b0, cell_next.den});
                cell_next.quo[0] = 1'b1;
            end
            else
            begin
                cell_next.rem = trial[DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/swg_div_chain.sv =====
`default_nettype none
module swg_div_chain import swg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      en,
    input  wire div_cell_t din,
    output div_cell_t      dout
);

    div_cell_t link [DIV_CELLS+1];

    assign link[0] = din;

    // row of divider cells, each passing its partial remainder on
    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_cell
        swg_div_cell u_cell
        (
            .clk  (clk),
            .en   (en),
            .din  (link[i]),
            .dout (link[i+1])
        );
    end

    assign dout = link[DIV_CELLS];

endmodule
`default_nettype wire

// ===== hw/rtl/swg_horner_cell.sv =====
`default_nettype none
module swg_horner_cell import swg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [31:0] coef,
    input  wire horner_t            din,
    output horner_t                 dout
);

    horner_t            cell_next;
    horner_t            cell_reg;
    logic signed [33:0] sum;

    // one horner step: acc = coef + acc * u^2
    always_comb
    begin
        sum           = 34'(coef) + mul_q30(din.acc, din.u2);
        cell_next     = din;
        cell_next.acc = sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/sine_wave_generator_top.sv =====
`default_nettype none
// Sine generator: each timestamp transaction (seconds plus milliseconds) yields one
// sample amplitude * sin(2*pi*(f*t + phase)) + offset in signed Q16.16, optionally
// rounded to decimal_places digits and saturated. One transaction is taken every
// clock while the pipeline is not stalled. The pipeline holds a chain of fifteen
// divider cells for the decimal rounding, a chain of six polynomial cells for the
// sine, three stages that take the millisecond phase fraction f*ms/1000 by an exact
// division, nine further stages and the output register. A stalled result holds the
// pipeline only when the last stage also holds a result. Configuration must be
// written only while no transaction is in flight; the block does not enforce it.
module sine_wave_generator_top import swg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        time_valid,
    output logic             time_stall,
    input  wire time_t       time_data,
    output logic             sample_valid,
    input  wire logic        sample_stall,
    output sample_t          sample_data,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // configuration registers
    logic [31:0]        cfg_freq_reg;
    logic [31:0]        cfg_phase_reg;
    logic signed [31:0] cfg_amp_reg;
    logic [31:0]        cfg_offset_reg;
    logic [3:0]         cfg_dec_reg;

    logic               en;
    logic [LAT-1:0]     vld_reg;
    logic [LAT-1:0]     vld_next;
    logic               bypass;
    logic [DEN_W-1:0]   p10;

    logic [15:0]        s1_alo_reg, s1_alo_next;
    logic [41:0]        s1_pm_reg, s1_pm_next;
    logic [15:0]        p1_sum_reg, p1_sum_next;
    logic [31-PHASE_SHIFT:0] p1_lo_reg, p2_lo_reg;
    logic [15:0]        p1_alo_reg, p2_alo_reg, p3_alo_reg;
    logic [9:0]         p2_fold;
    logic [6:0]         p2_t_reg, p2_t_next;
    logic [31:0]        p3_quo_reg, p3_quo_next;
    logic [31:0]        phase;
    logic [29:0]        phase_x;
    logic [30:0]        s3_u_reg, s3_u_next;
    logic [1:0]         s3_quad_reg;
    logic [61:0]        uu;
    horner_t            s4_h_reg, s4_h_next;
    horner_t            h_link [HORNER_CELLS+1];
    logic signed [33:0] s5_s_reg, s5_s_next;
    logic [1:0]         s5_quad_reg;
    logic [30:0]        s_clamp;
    logic [SIN_FRAC:0]  m;
    logic signed [SIN_W-1:0] s6_sine_reg, s6_sine_next;
    logic signed [PROD_W-1:0] s7_prod_reg, s7_prod_next;
    logic [PROD_W-1:0]  prod_mag;
    logic [PROD_W:0]    prod_rnd;
    logic [V_W-1:0]     q_s;
    logic [V_W-1:0]     s8_v_reg, s8_v_next;
    logic signed [PR_W-1:0] s9_pr_reg, s9_pr_next;
    logic [V_W-1:0]     s9_v_reg;
    logic [PR_W-1:0]    pr_mag;
    logic [PR_W:0]      pr_rnd;
    logic [V_W-1:0]     v_mag;
    logic [N_W-1:0]     s10_mag_reg, s10_mag_next;
    logic               s10_neg_reg, s10_neg_next;
    div_cell_t          d2_in, d2_out;
    logic signed [35:0] res;
    logic               out_valid_reg;
    sample_t            out_reg, out_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_freq_reg   <= 32'd65536;
            cfg_phase_reg  <= 32'd0;
            cfg_amp_reg    <= 32'sd65536;
            cfg_offset_reg <= 32'd0;
            cfg_dec_reg    <= 4'hF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FREQ:     cfg_freq_reg   <= cfg_data;
                REG_PHASE:    cfg_phase_reg  <= cfg_data;
                REG_AMP:      cfg_amp_reg    <= cfg_data;
                REG_OFFSET:   cfg_offset_reg <= cfg_data;
                REG_DECIMALS: cfg_dec_reg    <= cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    assign bypass = cfg_dec_reg[3];
    assign p10    = pow10(cfg_dec_reg[2:0]);

    // pipeline advances unless the last stage is blocked by a stalled output
    assign en         = !(vld_reg[LAT-1] && out_valid_reg && sample_stall);
    assign time_stall = !en;
    assign vld_next   = {vld_reg[LAT-2:0], time_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // products of frequency with seconds and milliseconds
    assign s1_alo_next = 16'(cfg_freq_reg[15:0] * time_data.time_seconds[15:0]);
    assign s1_pm_next  = 42'(cfg_freq_reg) * 42'(time_data.time_millis);

    // weighted chunk sum, congruent to (f * ms << 13) modulo 125
    always_comb
    begin
        p1_sum_next = '0;
        for (int i = 0; i < PH_CHUNKS; i++)
        begin
            p1_sum_next = p1_sum_next
                        + 16'(s1_pm_reg[7*i +: 7]) * 16'(phase_weight(3'(i)));
        end
    end

    // fold the chunk sum (2^7 and 2^14 are 3 and 9 modulo 125) and reduce
    always_comb
    begin
        p2_fold = 10'(p1_sum_reg[6:0]) + 10'(p1_sum_reg[13:7]) * 10'd3
                + 10'(p1_sum_reg[15:14]) * 10'd9;
        if (p2_fold >= 10'(4 * PHASE_DEN))
        begin
            p2_t_next = 7'(p2_fold - 10'(4 * PHASE_DEN));
        end
        else if (p2_fold >= 10'(3 * PHASE_DEN))
        begin
            p2_t_next = 7'(p2_fold - 10'(3 * PHASE_DEN));
        end
        else if (p2_fold >= 10'(2 * PHASE_DEN))
        begin
            p2_t_next = 7'(p2_fold - 10'(2 * PHASE_DEN));
        end
        else if (p2_fold >= 10'(PHASE_DEN))
        begin
            p2_t_next = 7'(p2_fold - 10'(PHASE_DEN));
        end
        else
        begin
            p2_t_next = 7'(p2_fold);
        end
    end

    // exact quotient modulo 2^32: remainder removed, times the inverse of 125
    assign p3_quo_next = ({p2_lo_reg, PHASE_SHIFT'(0)} - 32'(p2_t_reg)) * PHASE_INV;

    // phase sum and quadrant fold
    assign phase     = {p3_alo_reg, 16'd0} + p3_quo_reg + cfg_phase_reg;
    assign phase_x   = phase[29:0];
    assign s3_u_next = phase[30] ? 31'(31'h4000_0000 - {1'b0, phase_x}) : {1'b0, phase_x};

    // u squared, seeds the polynomial
    always_comb
    begin
        uu            = 62'(s3_u_reg) * 62'(s3_u_reg);
        s4_h_next.acc = sin_coef(3'd6);
        s4_h_next.u   = s3_u_reg;
        s4_h_next.u2  = uu[60:30];
        s4_h_next.quad = s3_quad_reg;
    end

    assign h_link[0] = s4_h_reg;

    for (genvar i = 0; i < HORNER_CELLS; i++)
    begin : g_horner
        swg_horner_cell u_cell
        (
            .clk  (clk),
            .en   (en),
            .coef (sin_coef(3'(HORNER_CELLS - 1 - i))),
            .din  (h_link[i]),
            .dout (h_link[i+1])
        );
    end

    // final multiply by u
    assign s5_s_next = mul_q30(h_link[HORNER_CELLS].acc, h_link[HORNER_CELLS].u);

    // clamp, round to the sine grid and apply quadrant sign
    always_comb
    begin
        if (s5_s_reg < 0)
        begin
            s_clamp = '0;
        end
        else if (s5_s_reg > 34'sh4000_0000)
        begin
            s_clamp = 31'h4000_0000;
        end
        else
        begin
            s_clamp = s5_s_reg[30:0];
        end
        m = (SIN_FRAC + 1)'((32'(s_clamp) + (32'd1 << (29 - SIN_FRAC))) >> (30 - SIN_FRAC));
        s6_sine_next = s5_quad_reg[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end

    // amplitude scaling
    assign s7_prod_next = s6_sine_reg * cfg_amp_reg;

    // back to Q16.16 rounded half away from zero, plus offset
    always_comb
    begin
        prod_mag  = s7_prod_reg[PROD_W-1] ? PROD_W'(-s7_prod_reg) : PROD_W'(s7_prod_reg);
        prod_rnd  = ({1'b0, prod_mag} + ((PROD_W + 1)'(1) << (SIN_FRAC - 1))) >> SIN_FRAC;
        q_s       = prod_rnd[V_W-1:0];
        s8_v_next = (s7_prod_reg[PROD_W-1] ? V_W'(~q_s + 1'b1) : q_s)
                  + {{(V_W - 32){cfg_offset_reg[31]}}, cfg_offset_reg};
    end

    // scale by the decimal step
    assign s9_pr_next = $signed(s8_v_reg) * $signed({1'b0, p10});

    // decimal count, or the value itself when rounding is off
    always_comb
    begin
        pr_mag = s9_pr_reg[PR_W-1] ? PR_W'(-s9_pr_reg) : PR_W'(s9_pr_reg);
        pr_rnd = ({1'b0, pr_mag} + (PR_W + 1)'(32768)) >> 16;
        v_mag  = s9_v_reg[V_W-1] ? V_W'(~s9_v_reg + 1'b1) : s9_v_reg;
        if (bypass)
        begin
            s10_mag_next = N_W'(v_mag);
            s10_neg_next = s9_v_reg[V_W-1];
        end
        else
        begin
            s10_mag_next = pr_rnd[N_W-1:0];
            s10_neg_next = s9_pr_reg[PR_W-1];
        end
    end

    // divide back by the decimal step with rounding
    always_comb
    begin
        d2_in     = '0;
        d2_in.aux = AUX_W'(s10_neg_reg);
        if (bypass)
        begin
            d2_in.num = NUM_W'(s10_mag_reg);
            d2_in.den = DEN_W'(1);
        end
        else
        begin
            d2_in.num = NUM_W'({s10_mag_reg, 16'd0}) + NUM_W'(p10 >> 1);
            d2_in.den = p10;
        end
    end

    swg_div_chain u_round_div
    (
        .clk  (clk),
        .en   (en),
        .din  (d2_in),
        .dout (d2_out)
    );

    // sign and saturation
    always_comb
    begin
        res = d2_out.aux[0] ? -$signed({1'b0, d2_out.quo[34:0]})
                            : $signed({1'b0, d2_out.quo[34:0]});
        if (res > 36'sd2147483647)
        begin
            out_next.sample_value = 32'sh7FFF_FFFF;
            out_next.saturated    = 1'b1;
        end
        else if (res < -36'sd2147483648)
        begin
            out_next.sample_value = 32'sh8000_0000;
            out_next.saturated    = 1'b1;
        end
        else
        begin
            out_next.sample_value = res[31:0];
            out_next.saturated    = 1'b0;
        end
    end

    // payload stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_alo_reg   <= s1_alo_next;
            s1_pm_reg    <= s1_pm_next;
            p1_sum_reg   <= p1_sum_next;
            p1_lo_reg    <= s1_pm_reg[31-PHASE_SHIFT:0];
            p1_alo_reg   <= s1_alo_reg;
            p2_t_reg     <= p2_t_next;
            p2_lo_reg    <= p1_lo_reg;
            p2_alo_reg   <= p1_alo_reg;
            p3_quo_reg   <= p3_quo_next;
            p3_alo_reg   <= p2_alo_reg;
            s3_u_reg     <= s3_u_next;
            s3_quad_reg  <= phase[31:30];
            s4_h_reg     <= s4_h_next;
            s5_s_reg     <= s5_s_next;
            s5_quad_reg  <= h_link[HORNER_CELLS].quad;
            s6_sine_reg  <= s6_sine_next;
            s7_prod_reg  <= s7_prod_next;
            s8_v_reg     <= s8_v_next;
            s9_pr_reg    <= s9_pr_next;
            s9_v_reg     <= s8_v_reg;
            s10_mag_reg  <= s10_mag_next;
            s10_neg_reg  <= s10_neg_next;
        end
    end

    // output register, holds while the transaction is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!(out_valid_reg && sample_stall))
        begin
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!(out_valid_reg && sample_stall))
        begin
            out_reg <= out_next;
        end
    end

    assign sample_valid = out_valid_reg;
    assign sample_data  = out_reg;

`include "assert_macros.svh"

    `ASSERT_SAME(a_hold_when_blocked, vld_reg[LAT-1] && sample_valid && sample_stall,
        time_stall, "pipeline not held behind a stalled result")
    `ASSERT_SAME(a_sat_at_limit, sample_valid && sample_data.saturated,
        sample_data.sample_value == 32'sh7FFF_FFFF || sample_data.sample_value == 32'sh8000_0000,
        "saturated flag without a limit value")
    `ASSERT_NEXT(a_no_invented, !sample_valid && !vld_reg[LAT-1], !sample_valid,
        "result appeared without a transaction in the last stage")

endmodule
`default_nettype wire

// ===== tb/sine_sample_checker.sv =====
`timescale 1ns / 100ps
module sine_sample_checker import swg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        time_valid,
    input  wire logic        time_stall,
    input  wire time_t       time_data,
    input  wire logic        sample_valid,
    input  wire logic        sample_stall,
    input  wire sample_t     sample_data,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               pending,
    output int               errors
);

    // shadow copy of the configuration
    logic [31:0] freq_q, phase_q, amp_q, offset_q;
    logic [3:0]  decimals_q;
    sample_t     expected_samples[$];

    function automatic longint abs64(input longint a);
        return a < 0 ? -a : a;
    endfunction

    // (a * b) >> 30 truncated toward zero
    function automatic longint q30_product(input longint a, input longint b);
        longint p;
        p = (abs64(a) * abs64(b)) >>> 30;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    // num / den rounded half away from zero
    function automatic longint round_div(input longint num, input longint den);
        longint q;
        q = (abs64(num) + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint taylor_coef(input int i);
        case (i)
            0: return 64'sd1686629713;
            1: return -64'sd693598668;
            2: return 64'sd85569306;
            3: return -64'sd5026995;
            4: return 64'sd172272;
            5: return -64'sd3864;
            default: return 64'sd61;
        endcase
    endfunction

    // sine of a Q0.32 phase, result with SIN_FRAC fraction bits
    function automatic longint sine_of_phase(input logic [31:0] ph);
        longint u, u2, acc, s, m;
        u = longint'(ph[29:0]);
        if (ph[30])
            u = (64'sd1 << 30) - u;
        u2 = q30_product(u, u);
        acc = taylor_coef(6);
        for (int i = 5; i >= 0; i--)
            acc = taylor_coef(i) + q30_product(acc, u2);
        s = q30_product(acc, u);
        if (s < 0)
            s = 0;
        if (s > (64'sd1 << 30))
            s = 64'sd1 << 30;
        m = (s + (64'sd1 << (29 - SIN_FRAC))) >>> (30 - SIN_FRAC);
        return ph[31] ? -m : m;
    endfunction

    function automatic sample_t compute_sample(input time_t t);
        longint f, fa, rem, fb, s, v, p10, n;
        logic [31:0] ph;
        sample_t r;
        f = longint'(freq_q);
        fa = ((f * longint'(t.time_seconds)) & 64'hFFFF) << 16;
        rem = (f * longint'(t.time_millis)) % 64'd65536000;
        fb = (rem << 16) / 1000;
        ph = 32'(fa + fb + longint'(phase_q));
        s = sine_of_phase(ph);
        v = round_div(s * longint'($signed(amp_q)), 64'sd1 << SIN_FRAC)
            + longint'($signed(offset_q));
        if (!decimals_q[3]) begin
            p10 = 1;
            for (int i = 0; i < int'(decimals_q[2:0]); i++)
                p10 = p10 * 10;
            n = round_div(v * p10, 65536);
            v = round_div(n * 65536, p10);
        end
        r.saturated = 1'b0;
        if (v > 64'sh7FFFFFFF) begin
            v = 64'sh7FFFFFFF;
            r.saturated = 1'b1;
        end else if (v < -64'sh80000000) begin
            v = -64'sh80000000;
            r.saturated = 1'b1;
        end
        r.sample_value = 32'(v);
        return r;
    endfunction

    assign pending = expected_samples.size();

    // track config, predict on accepted timestamps, compare on accepted samples
    always @(posedge clk or negedge rst_n)
    begin
        sample_t got, want;
        if (!rst_n) begin
            freq_q = 32'd65536;
            phase_q = 0;
            amp_q = 32'd65536;
            offset_q = 0;
            decimals_q = 4'hF;
            expected_samples.delete();
            errors = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    REG_FREQ:     freq_q = cfg_data;
                    REG_PHASE:    phase_q = cfg_data;
                    REG_AMP:      amp_q = cfg_data;
                    REG_OFFSET:   offset_q = cfg_data;
                    REG_DECIMALS: decimals_q = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (sample_valid && !sample_stall) begin
                got = sample_data;
                if (expected_samples.size() == 0) begin
                    $error("unexpected sample transaction %h", got);
                    errors++;
                end else begin
                    want = expected_samples.pop_front();
                    if (got.sample_value !== want.sample_value) begin
                        $error("sample_value expected %0d actual %0d",
                               want.sample_value, got.sample_value);
                        errors++;
                    end
                    if (got.saturated !== want.saturated) begin
                        $error("saturated expected %0b actual %0b",
                               want.saturated, got.saturated);
                        errors++;
                    end
                end
            end
            if (time_valid && !time_stall)
                expected_samples.push_back(compute_sample(time_data));
        end
    end

endmodule

// ===== tb/tb_sine_wave_generator_top.sv =====
`timescale 1ns / 100ps
module tb_sine_wave_generator_top;
    import swg_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        time_valid;
    logic        time_stall;
    time_t       time_data;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          pending;
    int          errors;
    logic        stall_enable;

    sine_wave_generator_top uut (.*);

    sine_sample_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stall: per-transaction random hold-off
    initial
    begin
        int n;
        sample_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_enable && sample_valid && !sample_stall) begin
                n = $urandom_range(0, 6);
                if (n > 0) begin
                    sample_stall = 1'b1;
                    repeat (n) @(negedge clk);
                    sample_stall = 1'b0;
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // wait until every sample has arrived, then let the pipeline drain
    task automatic drain_pipeline();
        while (pending != 0)
            @(negedge clk);
        repeat (LAT + 10) @(negedge clk);
    endtask

    // send one timestamp after an optional gap
    task automatic send_time(input logic [31:0] secs, input logic [9:0] ms, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            time_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        time_valid = 1'b1;
        time_data.time_seconds = secs;
        time_data.time_millis = ms;
        @(posedge clk);
        while (time_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic end_burst();
        time_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [31:0] dp;
        clk = 1'b0;
        rst_n = 1'b0;
        time_valid = 1'b0;
        time_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_FREQ;
        cfg_data = '0;
        stall_enable = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset config, field extremes, millis above 999
        send_time(32'd0, 10'd0, 0);
        send_time(32'hFFFF_FFFF, 10'd999, 0);
        send_time(32'd1, 10'd250, 0);
        send_time(32'd0, 10'd500, 0);
        send_time(32'd0, 10'd750, 0);
        send_time(32'd7, 10'd1023, 0);
        send_time(32'h5555_AAAA, 10'd1000, 0);
        end_burst();
        drain_pipeline();

        // rounding enabled, saturating amplitude and offset, then rounding off and an unused register index
        write_reg(REG_FREQ, 32'hFFFF_FFFF);
        write_reg(REG_PHASE, 32'h4000_0000);
        write_reg(REG_AMP, 32'h7FFF_FFFF);
        write_reg(REG_OFFSET, 32'h7FFF_FFFF);
        write_reg(REG_DECIMALS, 32'd0);
        send_time(32'd0, 10'd0, 0);
        send_time(32'd3, 10'd123, 0);
        send_time(32'hFFFF_FFFF, 10'd1023, 0);
        end_burst();
        drain_pipeline();
        write_reg(REG_AMP, 32'h8000_0000);
        write_reg(REG_OFFSET, 32'h8000_0000);
        write_reg(REG_DECIMALS, 32'd4);
        send_time(32'd0, 10'd0, 0);
        send_time(32'd12, 10'd888, 0);
        send_time(32'd99, 10'd1, 0);
        end_burst();
        drain_pipeline();
        write_reg(REG_FREQ, 32'd0);
        write_reg(REG_AMP, 32'h0003_0000);
        write_reg(REG_OFFSET, 32'hFFFF_8000);
        write_reg(REG_DECIMALS, 32'd7);
        send_time(32'd5, 10'd5, 0);
        end_burst();
        drain_pipeline();
        write_reg(REG_DECIMALS, 32'hF);
        write_reg(REG_DECIMALS, 32'h8);
        write_reg(3'd6, 32'h1234);
        send_time(32'd5, 10'd5, 0);
        end_burst();
        drain_pipeline();

        // random phases with fresh settings each time
        stall_enable = 1'b1;
        for (int phase_n = 0; phase_n < 19; phase_n++) begin
            write_reg(REG_FREQ, phase_n % 3 == 0 ? $urandom_range(0, 32'h0064_0000)
                                                 : pick_word());
            write_reg(REG_PHASE, pick_word());
            write_reg(REG_AMP, phase_n % 2 == 0 ? $urandom_range(0, 32'h0010_0000)
                                                : pick_word());
            write_reg(REG_OFFSET, phase_n % 2 == 0 ? 32'($signed($urandom_range(0, 32'h20_0000))
                                                    - 32'sh10_0000) : pick_word());
            dp = $urandom_range(0, 15);
            write_reg(REG_DECIMALS, dp);
            for (int i = 0; i < 50; i++)
                send_time($urandom_range(0, 3) == 0 ? pick_word() : $urandom_range(0, 10000),
                          $urandom_range(0, 7) == 0 ? 10'($urandom) : 10'($urandom_range(0, 999)),
                          phase_n % 4 != 3);
            end_burst();
            drain_pipeline();
        end

        end_burst();
        drain_pipeline();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // overall timeout
    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
